FILE: hw/rtl/ihse_pkg.sv
// Shared types and constants for the IPv4 header stream extractor.
package ihse_pkg;

	localparam int unsigned HDR_REST_LEN = 19;
	localparam int unsigned IDX_W        = 5;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HDR_REST_LEN - 1);

	localparam logic [7:0] ETYPE_HI   = 8'h08;
	localparam logic [7:0] ETYPE_LO   = 8'h00;
	localparam logic [3:0] IP_VERSION = 4'h4;

	localparam int unsigned REC_W = 160;

	// Packed so that the first field sits in the highest bits.
	typedef struct packed {
		logic [3:0]  pad;
		logic [63:0] address_pair;
		logic [15:0] header_sum;
		logic        proto_known;
		logic [7:0]  proto_number;
		logic [7:0]  hop_limit;
		logic [15:0] frag_offset_bytes;
		logic [2:0]  frag_flags;
		logic [15:0] ident;
		logic [15:0] total_length;
		logic [1:0]  ecn;
		logic [2:0]  service_bits;
		logic [2:0]  precedence;
	} record_t;

	function automatic logic is_known_proto(input logic [7:0] p);
		logic known;
		known = 1'b0;
		if (p >= 8'd1 && p <= 8'd7)
			known = 1'b1;
		if (p >= 8'd9 && p <= 8'd21)
			known = 1'b1;
		if (p == 8'd27 || p == 8'd33 || p == 8'd54 || p == 8'd121)
			known = 1'b1;
		return known;
	endfunction

endpackage

FILE: hw/rtl/ihse_parse.sv
// Header hunt, byte collection and record decode for one byte per cycle while en is high.
module ihse_parse import ihse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] byte_in,
	output logic       emit,
	output record_t    rec
);

	logic [7:0]       win0_q, win1_q;
	logic             collecting_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       hdr_q [HDR_REST_LEN-1];
	logic [7:0]       s [HDR_REST_LEN];
	logic             match;
	logic [15:0]      fw;

	assign match = (win0_q == ETYPE_HI) && (win1_q == ETYPE_LO) && (byte_in[7:4] == IP_VERSION);
	assign emit  = collecting_q && (idx_q == IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q       <= '0;
			win1_q       <= '0;
			collecting_q <= 1'b0;
			idx_q        <= '0;
		end else if (en) begin
			if (!collecting_q) begin
				win0_q <= win1_q;
				win1_q <= byte_in;
				if (match) begin
					collecting_q <= 1'b1;
					idx_q        <= '0;
				end
			end else if (idx_q < IDX_LAST) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				// Last header byte, or an impossible index: back to hunting.
				collecting_q <= 1'b0;
				idx_q        <= '0;
				win0_q       <= '0;
				win1_q       <= '0;
			end
		end
	end

	// The first 18 header bytes shift in; the 19th is taken straight from the input.
	always_ff @(posedge clk) begin
		if (en && collecting_q && idx_q < IDX_LAST) begin
			for (int i = 0; i < HDR_REST_LEN - 2; i++)
				hdr_q[i] <= hdr_q[i+1];
			hdr_q[HDR_REST_LEN-2] <= byte_in;
		end
	end

	always_comb begin
		for (int i = 0; i < HDR_REST_LEN - 1; i++)
			s[i] = hdr_q[i];
		s[HDR_REST_LEN-1] = byte_in;
	end

	assign fw = {s[5], s[6]};

	always_comb begin
		rec                   = '0;
		rec.precedence        = s[0][7:5];
		rec.service_bits      = s[0][4:2];
		rec.ecn               = s[0][1:0];
		rec.total_length      = {s[1], s[2]};
		rec.ident             = {s[3], s[4]};
		rec.frag_flags        = fw[15:13];
		rec.frag_offset_bytes = {fw[12:0], 3'b000};
		rec.hop_limit         = s[7];
		rec.proto_number      = s[8];
		rec.proto_known       = is_known_proto(s[8]);
		rec.header_sum        = {s[9], s[10]};
		rec.address_pair      = {s[11], s[12], s[13], s[14], s[15], s[16], s[17], s[18]};
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> idx_q <= IDX_LAST)
		else $error("header index beyond the last byte");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(en && emit) |=> (!collecting_q && win0_q == '0 && win1_q == '0))
		else $error("hunt state not cleared after a header");

	a_match_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !collecting_q && match) |=> (collecting_q && idx_q == '0))
		else $error("match did not start collection");

endmodule

FILE: hw/rtl/ipv4_header_stream_extractor.sv
// Top level: input register, header parser and output register.
//
//  Channel | Dir | Signals                     | Word
//  s_      | in  | s_tvalid s_tready s_tdata   | one capture byte
//  m_      | out | m_tvalid m_tready m_tdata   | one decoded IPv4 header record
//
// One byte is accepted per cycle unless a header's last byte waits on a held record;
// the rate is set by the combinational decode between the input and output registers.
// The arst_n reset clears the hunt window, the collect state and both valid flags.
// A stalled record holds the output register; input bytes that make no record keep flowing.
// Only a byte that completes a header waits while an earlier record is still held.
module ipv4_header_stream_extractor import ihse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // data_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	// precedence, service_bits, ecn, total_length, ident, frag_flags, frag_offset_bytes,
	// hop_limit, proto_number, proto_known, header_sum, address_pair, zero fill
	output logic [REC_W-1:0] m_tdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	record_t    out_rec_q;
	logic       emit;
	logic       advance;
	record_t    rec;

	assign advance  = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	ihse_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.byte_in (byte_s1),
		.emit    (emit),
		.rec     (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			out_rec_q <= rec;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_rec_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |-> (!out_valid_q || m_tready))
		else $error("record overwrote an untaken record");

	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input word lost");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> m_tvalid)
		else $error("record not presented");

endmodule
